// File: rtl/tcw_pkg.sv
package tcw_pkg;

   localparam int DEF_COLS = 80;
   localparam int DEF_ROWS = 25;

   localparam int MODE_W = 2;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int CELL_W = 16;
   localparam int RIDX_W = 11;
   localparam int OROW_W = 5;
   localparam int OCOL_W = 7;

   localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
   localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
   localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
   localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
   localparam logic [ATTR_W-1:0] ATTR_RESET   = 8'h07;
   localparam logic [CELL_W-1:0] CELL_RESET   = {ATTR_RESET, SPACE_CODE};

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_COPY,
      ST_FILL,
      ST_EMIT
   } tcw_state_type;

endpackage

// File: rtl/text_console_writer_top.sv
// channel  ports                                        direction
// req      req_valid req_stall req_mode req_char_code   in (stall out)
//          req_read_index
// rsp      rsp_valid rsp_stall rsp_cell_value           out (stall in)
//          rsp_cursor_row rsp_cursor_col rsp_scrolled
// csr      csr_wr_en csr_wr_data                        in
//
// one item at a time: req_stall is high whenever the FSM is not idle
// put or read: accept, then emit the result; clear: fill every cell, then emit
// put that scrolls: row copy, then bottom row fill, then emit
// after reset the buffer is cleared to 0x0720 while req_stall is high
// a result waits in the output register while rsp_stall is high
module text_console_writer_top
   import tcw_pkg::*;
#(
   parameter int COLS = DEF_COLS,
   parameter int ROWS = DEF_ROWS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [CHAR_W-1:0] req_char_code,
   input  logic [RIDX_W-1:0] req_read_index,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [CELL_W-1:0] rsp_cell_value,
   output logic [OROW_W-1:0] rsp_cursor_row,
   output logic [OCOL_W-1:0] rsp_cursor_col,
   output logic              rsp_scrolled,
   input  logic              csr_wr_en,
   input  logic [ATTR_W-1:0] csr_wr_data
);

   localparam int CELLS = COLS * ROWS;
   localparam int AW = $clog2(CELLS);
   localparam int RW = $clog2(ROWS);
   localparam int CW = $clog2(COLS);
   localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
   localparam logic [AW-1:0] BODY_A = AW'(CELLS - COLS);
   localparam logic [AW-1:0] COLS_A = AW'(COLS);
   localparam logic [RW-1:0] LAST_ROW = RW'(ROWS - 1);
   localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

   logic [CELL_W-1:0] mem [CELLS];

   tcw_state_type     state_ff, state_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CELL_W-1:0] fill_val_ff, fill_val_in;
   logic              copy_wr_ff, copy_wr_in;
   logic [CELL_W-1:0] rd_data_ff;
   logic [RW-1:0]     row_ff, row_in;
   logic [CW-1:0]     col_ff, col_in;
   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic              res_rd_ff, res_rd_in;
   logic              res_scr_ff, res_scr_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [CELL_W-1:0] rsp_value_ff, rsp_value_in;
   logic [OROW_W-1:0] rsp_row_ff, rsp_row_in;
   logic [OCOL_W-1:0] rsp_col_ff, rsp_col_in;
   logic              rsp_scr_ff, rsp_scr_in;

   logic              mem_we;
   logic [AW-1:0]     mem_wa;
   logic [CELL_W-1:0] mem_wd;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;

   logic          acc;
   logic          is_nl;
   logic          line_end;
   logic          wrap;
   logic          rd_in_range;
   logic          emit_ok;
   logic [AW-1:0] cur_addr;

   assign acc         = (state_ff == ST_IDLE) && req_valid;
   assign is_nl       = (req_char_code == NEWLINE_CODE);
   assign line_end    = (col_ff == LAST_COL) || is_nl;
   assign wrap        = line_end && (row_ff == LAST_ROW);
   assign rd_in_range = 32'(req_read_index) < 32'(CELLS);
   assign emit_ok     = !rsp_valid_ff || !rsp_stall;
   assign cur_addr    = AW'(AW'(row_ff) * COLS_A + AW'(col_ff));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_INIT: begin
            if (ptr_ff == LAST_A) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (acc) begin
               if ((req_mode == MODE_PUT) && wrap) begin
                  state_in = ST_COPY;
               end else if (req_mode == MODE_CLEAR) begin
                  state_in = ST_FILL;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_COPY: begin
            if (ptr_ff == BODY_A) state_in = ST_FILL;
         end
         ST_FILL: begin
            if (ptr_ff == LAST_A) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_ok) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and memory control
   always_comb begin
      mem_we       = 1'b0;
      mem_wa       = ptr_ff;
      mem_wd       = fill_val_ff;
      rd_en        = 1'b0;
      rd_addr      = AW'(ptr_ff + COLS_A);
      ptr_in       = ptr_ff;
      fill_val_in  = fill_val_ff;
      copy_wr_in   = 1'b0;
      row_in       = row_ff;
      col_in       = col_ff;
      res_rd_in    = res_rd_ff;
      res_scr_in   = res_scr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_value_in = rsp_value_ff;
      rsp_row_in   = rsp_row_ff;
      rsp_col_in   = rsp_col_ff;
      rsp_scr_in   = rsp_scr_ff;
      attr_in      = csr_wr_en ? csr_wr_data : attr_ff;
      case (state_ff)
         ST_INIT: begin
            mem_we = 1'b1;
            mem_wd = CELL_RESET;
            ptr_in = (ptr_ff == LAST_A) ? '0 : AW'(ptr_ff + 1'b1);
         end
         ST_IDLE: begin
            res_rd_in  = 1'b0;
            res_scr_in = 1'b0;
            if (acc) begin
               case (req_mode)
                  MODE_PUT: begin
                     mem_we = !is_nl;
                     mem_wa = cur_addr;
                     mem_wd = {attr_ff, req_char_code};
                     if (line_end) begin
                        col_in = '0;
                        if (wrap) begin
                           res_scr_in  = 1'b1;
                           ptr_in      = '0;
                           fill_val_in = {attr_ff, SPACE_CODE};
                        end else begin
                           row_in = RW'(row_ff + 1'b1);
                        end
                     end else begin
                        col_in = CW'(col_ff + 1'b1);
                     end
                  end
                  MODE_CLEAR: begin
                     ptr_in      = '0;
                     fill_val_in = {attr_ff, SPACE_CODE};
                  end
                  MODE_READ: begin
                     if (rd_in_range) begin
                        rd_en     = 1'b1;
                        rd_addr   = AW'(req_read_index);
                        res_rd_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_COPY: begin
            // read row below, write it one row up in the next cycle
            rd_en      = (ptr_ff != BODY_A);
            copy_wr_in = rd_en;
            if (copy_wr_ff) begin
               mem_we = 1'b1;
               mem_wa = AW'(ptr_ff - 1'b1);
               mem_wd = rd_data_ff;
            end
            if (ptr_ff != BODY_A) ptr_in = AW'(ptr_ff + 1'b1);
         end
         ST_FILL: begin
            mem_we = 1'b1;
            ptr_in = (ptr_ff == LAST_A) ? '0 : AW'(ptr_ff + 1'b1);
         end
         ST_EMIT: begin
            if (emit_ok) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = res_rd_ff ? rd_data_ff : '0;
               rsp_row_in   = OROW_W'(row_ff);
               rsp_col_in   = OCOL_W'(col_ff);
               rsp_scr_in   = res_scr_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         ptr_ff       <= '0;
         copy_wr_ff   <= 1'b0;
         row_ff       <= '0;
         col_ff       <= '0;
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ptr_ff       <= ptr_in;
         copy_wr_ff   <= copy_wr_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fill_val_ff  <= fill_val_in;
      res_rd_ff    <= res_rd_in;
      res_scr_ff   <= res_scr_in;
      rsp_value_ff <= rsp_value_in;
      rsp_row_ff   <= rsp_row_in;
      rsp_col_ff   <= rsp_col_in;
      rsp_scr_ff   <= rsp_scr_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_value = rsp_value_ff;
   assign rsp_cursor_row = rsp_row_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_scrolled   = rsp_scr_ff;

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (row_ff <= LAST_ROW) && (col_ff <= LAST_COL))
      else $error("cursor out of range");

   a_scroll_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scrolled) |->
         (rsp_cursor_col == '0) && (rsp_cursor_row == OROW_W'(ROWS - 1)))
      else $error("scrolled item without cursor on last row");

   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      (mem_we && (state_ff == ST_IDLE)) |-> (acc && (req_mode == MODE_PUT)))
      else $error("cell write while idle without a put item");

   a_copy_write: assert property (@(posedge clock) disable iff (reset)
      copy_wr_ff |-> (state_ff == ST_COPY))
      else $error("row copy write outside scroll");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EMIT))
      else $error("result shown outside emit");

endmodule

// File: tb/tb_text_console_writer_top.sv
module tb_text_console_writer_top;
   import tcw_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int COLS  = DEF_COLS;
   localparam int ROWS  = DEF_ROWS;
   localparam int CELLS = COLS * ROWS;
   localparam int CYCLE_LIMIT = 8_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam logic [MODE_W-1:0] MODE_NOOP = 2'd3;

   typedef struct packed {
      logic [CELL_W-1:0] cell_value;
      logic [OROW_W-1:0] cursor_row;
      logic [OCOL_W-1:0] cursor_col;
      logic              scrolled;
   } console_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_valid;
   logic              req_stall;
   logic [MODE_W-1:0] req_mode;
   logic [CHAR_W-1:0] req_char_code;
   logic [RIDX_W-1:0] req_read_index;
   logic              rsp_valid;
   logic              rsp_stall;
   logic [CELL_W-1:0] rsp_cell_value;
   logic [OROW_W-1:0] rsp_cursor_row;
   logic [OCOL_W-1:0] rsp_cursor_col;
   logic              rsp_scrolled;
   logic              csr_wr_en;
   logic [ATTR_W-1:0] csr_wr_data;

   // console model
   logic [CELL_W-1:0] screen_model [CELLS];
   int                model_row;
   int                model_col;
   logic [ATTR_W-1:0] model_attr;

   console_result_type console_expect_q [$];
   console_result_type oldest_result;

   int req_idle_pct;
   int rsp_idle_pct;
   int error_count;
   int cycle_count;
   int n_puts, n_newlines, n_scrolls, n_clears, n_reads, n_far_reads, n_noops, n_attrs;

   text_console_writer_top #(
      .COLS(COLS),
      .ROWS(ROWS)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_mode       (req_mode),
      .req_char_code  (req_char_code),
      .req_read_index (req_read_index),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_cell_value (rsp_cell_value),
      .rsp_cursor_row (rsp_cursor_row),
      .rsp_cursor_col (rsp_cursor_col),
      .rsp_scrolled   (rsp_scrolled),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   function automatic void console_reset_model();
      int i;
      for (i = 0; i < CELLS; i++) screen_model[i] = CELL_RESET;
      model_row  = 0;
      model_col  = 0;
      model_attr = ATTR_RESET;
   endfunction

   // advance the console model by one item and queue the result it yields
   function automatic void console_predict(input logic [MODE_W-1:0] mode,
                                           input logic [CHAR_W-1:0] ch,
                                           input logic [RIDX_W-1:0] ridx);
      console_result_type r;
      int i;
      r = '0;
      case (mode)
         MODE_PUT: begin
            n_puts++;
            if (ch != NEWLINE_CODE) begin
               screen_model[model_row * COLS + model_col] = {model_attr, ch};
            end else begin
               n_newlines++;
            end
            model_col++;
            if (model_col >= COLS || ch == NEWLINE_CODE) begin
               model_col = 0;
               model_row++;
               if (model_row >= ROWS) begin
                  for (i = 0; i < CELLS - COLS; i++) screen_model[i] = screen_model[i + COLS];
                  for (i = CELLS - COLS; i < CELLS; i++) screen_model[i] = {model_attr, SPACE_CODE};
                  model_row  = ROWS - 1;
                  r.scrolled = 1'b1;
                  n_scrolls++;
               end
            end
         end
         MODE_CLEAR: begin
            n_clears++;
            for (i = 0; i < CELLS; i++) screen_model[i] = {model_attr, SPACE_CODE};
         end
         MODE_READ: begin
            n_reads++;
            if (ridx < CELLS) r.cell_value = screen_model[ridx];
            else n_far_reads++;
         end
         default: n_noops++;
      endcase
      r.cursor_row = model_row[OROW_W-1:0];
      r.cursor_col = model_col[OCOL_W-1:0];
      console_expect_q.push_back(r);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (console_expect_q.size() == 0) begin
            $error("result with no item waiting: cell %h row %0d col %0d scrolled %0d",
                   rsp_cell_value, rsp_cursor_row, rsp_cursor_col, rsp_scrolled);
            error_count++;
         end else begin
            oldest_result = console_expect_q.pop_front();
            if (rsp_cell_value !== oldest_result.cell_value) begin
               $error("cell_value expected %h actual %h", oldest_result.cell_value,
                      rsp_cell_value);
               error_count++;
            end
            if (rsp_cursor_row !== oldest_result.cursor_row) begin
               $error("cursor_row expected %0d actual %0d", oldest_result.cursor_row,
                      rsp_cursor_row);
               error_count++;
            end
            if (rsp_cursor_col !== oldest_result.cursor_col) begin
               $error("cursor_col expected %0d actual %0d", oldest_result.cursor_col,
                      rsp_cursor_col);
               error_count++;
            end
            if (rsp_scrolled !== oldest_result.scrolled) begin
               $error("scrolled expected %0d actual %0d", oldest_result.scrolled,
                      rsp_scrolled);
               error_count++;
            end
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               console_expect_q.size());
      $display("Test completed with failures");
      $finish;
   end

   // called at a rising edge, returns at the edge where the item was taken
   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                            input logic [RIDX_W-1:0] ridx);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_mode       <= mode;
      req_char_code  <= ch;
      req_read_index <= ridx;
      do @(posedge clock); while (req_stall);
      console_predict(mode, ch, ridx);
   endtask

   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (console_expect_q.size() != 0) @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic write_attr(input logic [ATTR_W-1:0] value);
      wait_quiet();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      model_attr = value;
      n_attrs++;
      @(posedge clock);
   endtask

   task automatic test_reset_contents();
      send_item(MODE_READ, 8'h00, 11'd0);
      send_item(MODE_READ, 8'hFF, 11'd1999);
      send_item(MODE_READ, 8'h00, 11'd2000);
      send_item(MODE_READ, 8'h00, 11'd2047);
      send_item(MODE_NOOP, 8'hFF, 11'd2047);
   endtask

   task automatic test_put_chars();
      send_item(MODE_PUT, 8'h00, 11'd0);
      send_item(MODE_PUT, 8'h7F, 11'd2047);
      write_attr(8'hFF);
      send_item(MODE_PUT, 8'hFF, 11'd0);
      send_item(MODE_PUT, 8'h80, 11'd0);
      send_item(MODE_PUT, NEWLINE_CODE, 11'd0);
      send_item(MODE_READ, 8'h00, 11'd0);
      send_item(MODE_READ, 8'h00, 11'd1);
      send_item(MODE_READ, 8'h00, 11'd2);
      send_item(MODE_READ, 8'h00, 11'd3);
      send_item(MODE_READ, 8'h00, 11'd80);
   endtask

   task automatic test_clear_screen();
      write_attr(8'h00);
      send_item(MODE_CLEAR, 8'h41, 11'd5);
      send_item(MODE_READ, 8'h00, 11'd0);
      send_item(MODE_READ, 8'h00, 11'd1999);
      write_attr(8'h1E);
      send_item(MODE_CLEAR, 8'h00, 11'd0);
      send_item(MODE_PUT, 8'h5A, 11'd0);
      send_item(MODE_READ, 8'h00, 11'd80);
      send_item(MODE_READ, 8'h00, 11'd81);
   endtask

   function automatic logic [RIDX_W-1:0] pick_read_index();
      int sel;
      int idx;
      sel = $urandom_range(9);
      if (sel == 0) begin
         idx = $urandom_range(2047, CELLS);
      end else if (sel <= 3) begin
         idx = model_row * COLS + model_col - int'($urandom_range(3));
         if (idx < 0) idx = 0;
      end else if (sel <= 5) begin
         idx = CELLS - COLS + int'($urandom_range(COLS - 1));
      end else begin
         idx = $urandom_range(CELLS - 1);
      end
      return idx[RIDX_W-1:0];
   endfunction

   task automatic test_random_phase(input int send_idle, input int recv_idle, input int n_items,
                                    input logic [ATTR_W-1:0] attr_a,
                                    input logic [ATTR_W-1:0] attr_b);
      int sent;
      int len;
      int i;
      int sel;
      bit paused;
      logic [MODE_W-1:0] mode;
      req_idle_pct = send_idle;
      rsp_idle_pct = recv_idle;
      write_attr(attr_a);
      sent   = 0;
      paused = 0;
      while (sent < n_items) begin
         if (!paused && sent >= n_items / 2) begin
            // drain fully, then change the attribute mid-phase
            write_attr(attr_b);
            paused = 1;
         end
         sel = $urandom_range(99);
         if (sel < 55) begin
            // a line of text, sometimes long enough to wrap
            len = ($urandom_range(9) == 0) ? $urandom_range(170, 70) : $urandom_range(20, 1);
            for (i = 0; i < len && sent < n_items; i++) begin
               send_item(MODE_PUT, CHAR_W'($urandom_range(255)),
                         RIDX_W'($urandom_range(2047)));
               sent++;
            end
            if ($urandom_range(1) && sent < n_items) begin
               send_item(MODE_PUT, NEWLINE_CODE, RIDX_W'($urandom_range(2047)));
               sent++;
            end
         end else if (sel < 80) begin
            len = $urandom_range(6, 1);
            for (i = 0; i < len && sent < n_items; i++) begin
               send_item(MODE_READ, CHAR_W'($urandom_range(255)), pick_read_index());
               sent++;
            end
         end else begin
            sel = $urandom_range(19);
            if (sel == 0) mode = MODE_CLEAR;
            else if (sel <= 4) mode = MODE_NOOP;
            else if (sel <= 12) mode = MODE_PUT;
            else mode = MODE_READ;
            send_item(mode, ($urandom_range(3) == 0) ? NEWLINE_CODE : CHAR_W'($urandom_range(255)),
                      RIDX_W'($urandom_range(2047)));
            sent++;
         end
      end
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_mode       = MODE_PUT;
      req_char_code  = '0;
      req_read_index = '0;
      rsp_stall      = 1'b0;
      csr_wr_en      = 1'b0;
      csr_wr_data    = '0;
      req_idle_pct   = 0;
      rsp_idle_pct   = 0;
      error_count    = 0;
      n_puts = 0; n_newlines = 0; n_scrolls = 0; n_clears = 0;
      n_reads = 0; n_far_reads = 0; n_noops = 0; n_attrs = 0;
      console_reset_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_contents();
      test_put_chars();
      test_clear_screen();
      test_random_phase(9, 69, 320, 8'($urandom_range(255)), 8'($urandom_range(255)));
      test_random_phase(69, 9, 320, 8'hFF, 8'($urandom_range(255)));
      test_random_phase(0, 0, 320, 8'h00, 8'($urandom_range(255)));

      wait_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d puts (%0d newlines, %0d scrolls), %0d clears, %0d reads",
               n_puts, n_newlines, n_scrolls, n_clears, n_reads);
      $display("with %0d reads past the buffer, %0d no-op items, %0d attribute writes",
               n_far_reads, n_noops, n_attrs);
      if (console_expect_q.size() != 0) begin
         $error("%0d expected results never arrived", console_expect_q.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
